// ===== rtl/core/drag_scroll_axis_lock_macros.svh =====
// assertion macros for the drag scroll axis lock block
// used by modules that sample i_clk and i_rst_n
`ifndef DRAG_SCROLL_AXIS_LOCK_MACROS_SVH
`define DRAG_SCROLL_AXIS_LOCK_MACROS_SVH

// same-cycle implication
`define DSAL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dsal same-cycle check failed");

// next-cycle implication
`define DSAL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dsal next-cycle check failed");

`endif

// ===== rtl/core/dsal_pkg.sv =====
// shared types and constants for the drag scroll axis lock block
// no dependencies
package dsal_pkg;

    typedef enum logic [1:0] {
        AX_NONE = 2'd0,
        AX_X    = 2'd1,
        AX_Y    = 2'd2
    } t_axis;

    typedef enum logic [2:0] {
        REG_THR_H   = 3'd0,
        REG_THR_V   = 3'd1,
        REG_DIV_H   = 3'd2,
        REG_DIV_V   = 3'd3,
        REG_RATE    = 3'd4,
        REG_EXPIRE  = 3'd5,
        REG_LOCK_TO = 3'd6,
        REG_RATIO   = 3'd7
    } t_reg_idx;

    localparam int unsigned PADDR_W = 5;

    localparam logic [7:0]  RST_THR_H   = 8'd6;
    localparam logic [7:0]  RST_THR_V   = 8'd6;
    localparam logic [7:0]  RST_DIV_H   = 8'd8;
    localparam logic [7:0]  RST_DIV_V   = 8'd8;
    localparam logic [15:0] RST_RATE    = 16'd16;
    localparam logic [15:0] RST_EXPIRE  = 16'd100;
    localparam logic [15:0] RST_LOCK_TO = 16'd40;
    localparam logic [3:0]  RST_RATIO   = 4'd3;

    typedef struct packed {
        logic [7:0]  thr_h;
        logic [7:0]  thr_v;
        logic [7:0]  div_h;
        logic [7:0]  div_v;
        logic [15:0] rate;
        logic [15:0] expire;
        logic [15:0] lock_to;
        logic [3:0]  ratio;
    } t_cfg;

endpackage

// ===== rtl/core/dsal_cfg.sv =====
// apb configuration registers for the drag scroll axis lock block
// depends on dsal_pkg
module dsal_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsal_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output dsal_pkg::t_cfg                o_cfg
);
    import dsal_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_h   <= RST_THR_H;
            r_cfg.thr_v   <= RST_THR_V;
            r_cfg.div_h   <= RST_DIV_H;
            r_cfg.div_v   <= RST_DIV_V;
            r_cfg.rate    <= RST_RATE;
            r_cfg.expire  <= RST_EXPIRE;
            r_cfg.lock_to <= RST_LOCK_TO;
            r_cfg.ratio   <= RST_RATIO;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THR_H:   r_cfg.thr_h   <= pwdata[7:0];
                REG_THR_V:   r_cfg.thr_v   <= pwdata[7:0];
                REG_DIV_H:   r_cfg.div_h   <= pwdata[7:0];
                REG_DIV_V:   r_cfg.div_v   <= pwdata[7:0];
                REG_RATE:    r_cfg.rate    <= pwdata[15:0];
                REG_EXPIRE:  r_cfg.expire  <= pwdata[15:0];
                REG_LOCK_TO: r_cfg.lock_to <= pwdata[15:0];
                REG_RATIO:   r_cfg.ratio   <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THR_H:   prdata = {24'd0, r_cfg.thr_h};
            REG_THR_V:   prdata = {24'd0, r_cfg.thr_v};
            REG_DIV_H:   prdata = {24'd0, r_cfg.div_h};
            REG_DIV_V:   prdata = {24'd0, r_cfg.div_v};
            REG_RATE:    prdata = {16'd0, r_cfg.rate};
            REG_EXPIRE:  prdata = {16'd0, r_cfg.expire};
            REG_LOCK_TO: prdata = {16'd0, r_cfg.lock_to};
            REG_RATIO:   prdata = {28'd0, r_cfg.ratio};
        endcase
    end

endmodule

// ===== rtl/core/dsal_div.sv =====
// shared restoring divider, one quotient bit per cycle, 8 bit divisor
// depends on dsal_pkg
module dsal_div #(
    parameter int unsigned ACCUM_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ACCUM_WIDTH-1:0] i_dividend,
    input  logic [7:0]             i_divisor,
    output logic                   o_done,
    output logic [ACCUM_WIDTH-1:0] o_quot,
    output logic [7:0]             o_rem
);
    import dsal_pkg::*;

    localparam int unsigned CNT_W = $clog2(ACCUM_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACCUM_WIDTH - 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [ACCUM_WIDTH-1:0] r_acc, n_acc;
    logic [7:0]             r_rem, n_rem;
    logic [7:0]             r_dvs, n_dvs;
    logic [8:0]             w_trial;
    logic                   w_ge;

    assign w_trial = {r_rem, r_acc[ACCUM_WIDTH-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? 8'(w_trial - {1'b0, r_dvs}) : w_trial[7:0];
            n_acc = {r_acc[ACCUM_WIDTH-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_acc;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/drag_scroll_axis_lock.sv =====
// top level of the drag scroll axis lock block: sequencer and state
// depends on dsal_pkg, dsal_cfg, dsal_div and drag_scroll_axis_lock_macros.svh
//
// channel   direction  handshake                 payload
// s_axis    in         tvalid/tready             dx, dy, h_in, v_in, now_ms
// m_axis    out        tvalid/tready             h_out, v_out, scrolled
// apb       in         psel/penable/pwrite       register write and read
//
// from the accepting edge the sequencer passes S_AGE, S_ACC, S_MAG and S_LOCK before the result is
// registered; with a step it also passes S_DIV and S_FIN; the bit-serial divider sets the long path
// reset is synchronous and active low; config registers reset to their listed values
// s_axis_tready is low while a report is in work or a result waits on m_axis
`include "drag_scroll_axis_lock_macros.svh"
module drag_scroll_axis_lock #(
    parameter int unsigned ACCUM_WIDTH  = 32,
    parameter int unsigned MOTION_WIDTH = 16,
    parameter int unsigned STAMP_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // dx[15:0], dy[31:16], h_in[39:32], v_in[47:40], now_ms[79:48]
    input  logic [79:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // h_out[7:0], v_out[15:8], scrolled[16], zero fill above
    output logic [23:0]                  m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dsal_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dsal_pkg::*;

    localparam int unsigned AW = ACCUM_WIDTH;
    localparam int unsigned SW = STAMP_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_AGE  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_MAG  = 7'b0001000,
        S_LOCK = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_cfg w_cfg;
    t_state r_state, n_state;
    t_axis  r_lock, n_lock;

    logic signed [AW-1:0] r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [SW-1:0]        r_last_mot, n_last_mot, r_last_scr, n_last_scr;
    logic [AW-1:0]        r_ax, r_ay;
    logic [AW+3:0]        r_ax_r, r_ay_r;

    logic signed [AW-1:0] r_dx, r_dy;
    logic signed [7:0]    r_h, r_v;
    logic [SW-1:0]        r_now;
    logic                 r_moved;
    logic                 r_expire, r_lock_old, r_active, r_rate_ok;
    logic                 r_neg, n_neg;

    logic                 r_out_valid, n_out_valid;
    logic [23:0]          r_out_data, n_out_data;

    logic [SW-1:0]        w_age, w_scr_age;
    logic                 w_take;
    logic signed [AW:0]   w_sum_x, w_sum_y;
    logic signed [AW-1:0] w_base_x, w_base_y;
    logic [AW-1:0]        w_mag_x, w_mag_y;
    logic                 w_mx, w_my, w_ctx, w_cty, w_go;
    logic                 w_div_start, w_div_done;
    logic [AW-1:0]        w_quot, w_dividend;
    logic [7:0]           w_rem, w_dvs_raw, w_dvs;
    logic                 w_isx;
    logic signed [7:0]    w_sel, w_clamped;
    logic signed [9:0]    w_sum10;
    logic signed [AW-1:0] w_newbuf, w_cross, w_half, w_dec;
    logic [AW-1:0]        w_half_mag;
    logic [7:0]           w_cross_thr;

    dsal_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dsal_div #(.ACCUM_WIDTH(AW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dx    <= AW'(signed'(s_axis_tdata[MOTION_WIDTH-1:0]));
            r_dy    <= AW'(signed'(s_axis_tdata[16+MOTION_WIDTH-1:16]));
            r_h     <= s_axis_tdata[39:32];
            r_v     <= s_axis_tdata[47:40];
            r_now   <= s_axis_tdata[48+SW-1:48];
            r_moved <= (s_axis_tdata[MOTION_WIDTH-1:0] != '0)
                    || (s_axis_tdata[16+MOTION_WIDTH-1:16] != '0);
        end
    end

    // ages and limits
    assign w_age     = r_now - r_last_mot;
    assign w_scr_age = r_now - r_last_scr;

    always_ff @(posedge i_clk) begin
        if (r_state == S_AGE) begin
            r_expire   <= w_age > SW'(w_cfg.expire);
            r_lock_old <= w_age > SW'(w_cfg.lock_to);
            r_active   <= r_moved || (w_age <= SW'(w_cfg.lock_to));
            r_rate_ok  <= w_scr_age >= SW'(w_cfg.rate);
        end
    end

    // expiry then saturating accumulate
    always_comb begin
        logic any_state;
        any_state = (r_acc_x != '0) || (r_acc_y != '0) || (r_lock != AX_NONE);
        w_base_x  = (any_state && r_expire) ? '0 : r_acc_x;
        w_base_y  = (any_state && r_expire) ? '0 : r_acc_y;
        w_sum_x   = (AW+1)'(w_base_x) + (AW+1)'(r_dx);
        w_sum_y   = (AW+1)'(w_base_y) + (AW+1)'(r_dy);
    end

    // magnitudes and ratio products
    assign w_mag_x = r_acc_x[AW-1] ? AW'(-r_acc_x) : AW'(r_acc_x);
    assign w_mag_y = r_acc_y[AW-1] ? AW'(-r_acc_y) : AW'(r_acc_y);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAG) begin
            r_ax   <= w_mag_x;
            r_ay   <= w_mag_y;
            r_ax_r <= (AW+4)'(w_mag_x) * (AW+4)'(w_cfg.ratio);
            r_ay_r <= (AW+4)'(w_mag_y) * (AW+4)'(w_cfg.ratio);
        end
    end

    assign w_ctx = r_ax >= AW'(w_cfg.thr_h);
    assign w_cty = r_ay >= AW'(w_cfg.thr_v);
    assign w_mx  = w_ctx && ((AW+4)'(r_ax) >= r_ay_r);
    assign w_my  = w_cty && ((AW+4)'(r_ay) >= r_ax_r);

    // lock decision with hysteresis
    always_comb begin
        n_lock = r_lock;
        w_go   = 1'b0;
        if (r_lock == AX_NONE) begin
            if (r_active && (w_mx != w_my)) begin
                n_lock = w_mx ? AX_X : AX_Y;
                w_go   = 1'b1;
            end
        end else if (!r_active) begin
            n_lock = AX_NONE;
        end else if ((r_lock == AX_X) ? w_mx : w_my) begin
            w_go = 1'b1;
        end else if (!w_ctx && !w_cty) begin
            n_lock = AX_NONE;
        end else begin
            w_go = 1'b1;
            if ((r_lock == AX_X) ? w_my : w_mx) begin
                n_lock = (r_lock == AX_X) ? AX_Y : AX_X;
            end
        end
    end

    assign w_isx       = (r_lock == AX_X);
    assign w_dividend  = (n_lock == AX_X) ? r_ax : r_ay;
    assign w_dvs_raw   = (n_lock == AX_X) ? w_cfg.div_h : w_cfg.div_v;
    assign w_dvs       = (w_dvs_raw == '0) ? 8'd1 : w_dvs_raw;
    assign w_div_start = (r_state == S_LOCK) && r_rate_ok && w_go;

    // step, clamp and cross decay
    always_comb begin
        w_sel    = w_isx ? r_h : r_v;
        w_sum10  = r_neg ? (10'(w_sel) - signed'({2'b00, w_quot[7:0]}))
                         : (10'(w_sel) + signed'({2'b00, w_quot[7:0]}));
        if (w_quot[AW-1:8] != '0) begin
            w_clamped = r_neg ? -8'sd128 : 8'sd127;
        end else if (w_sum10 > 10'sd127) begin
            w_clamped = 8'sd127;
        end else if (w_sum10 < -10'sd128) begin
            w_clamped = -8'sd128;
        end else begin
            w_clamped = w_sum10[7:0];
        end
        w_newbuf    = r_neg ? -AW'(w_rem) : AW'(w_rem);
        w_cross     = w_isx ? r_acc_y : r_acc_x;
        w_cross_thr = w_isx ? w_cfg.thr_v : w_cfg.thr_h;
        w_half      = (w_cross + signed'(AW'(w_cross[AW-1]))) >>> 1;
        w_half_mag  = w_half[AW-1] ? AW'(-w_half) : AW'(w_half);
        w_dec       = (w_half_mag < AW'(w_cross_thr)) ? '0 : w_half;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_last_mot  = r_last_mot;
        n_last_scr  = r_last_scr;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) n_state = S_AGE;
            end
            S_AGE: n_state = S_ACC;
            S_ACC: begin
                n_acc_x = w_base_x;
                n_acc_y = w_base_y;
                if (r_moved) begin
                    n_acc_x = (w_sum_x[AW] != w_sum_x[AW-1])
                            ? {w_sum_x[AW], {(AW-1){~w_sum_x[AW]}}} : w_sum_x[AW-1:0];
                    n_acc_y = (w_sum_y[AW] != w_sum_y[AW-1])
                            ? {w_sum_y[AW], {(AW-1){~w_sum_y[AW]}}} : w_sum_y[AW-1:0];
                    n_last_mot = r_now;
                end
                n_state = S_MAG;
            end
            S_MAG: n_state = S_LOCK;
            S_LOCK: begin
                if (w_div_start) begin
                    n_neg   = (n_lock == AX_X) ? r_acc_x[AW-1] : r_acc_y[AW-1];
                    n_state = S_DIV;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, 1'b0, r_v, r_h};
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_done) n_state = S_FIN;
            end
            S_FIN: begin
                n_out_valid = 1'b1;
                if (w_quot != '0) begin
                    if (w_isx) begin
                        n_acc_x    = w_newbuf;
                        n_acc_y    = w_dec;
                        n_out_data = {7'd0, 1'b1, r_v, w_clamped};
                    end else begin
                        n_acc_y    = w_newbuf;
                        n_acc_x    = w_dec;
                        n_out_data = {7'd0, 1'b1, w_clamped, r_h};
                    end
                    n_last_scr = r_now;
                end else begin
                    n_out_data = {7'd0, 1'b0, r_v, r_h};
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lock      <= AX_NONE;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_last_mot  <= '0;
            r_last_scr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            r_last_mot  <= n_last_mot;
            r_last_scr  <= n_last_scr;
            r_out_valid <= n_out_valid;
            if (r_state == S_ACC && r_expire && r_lock != AX_NONE) begin
                r_lock <= AX_NONE;
            end else if (r_state == S_ACC && r_lock_old) begin
                r_lock <= AX_NONE;
            end else if (r_state == S_LOCK && r_rate_ok) begin
                r_lock <= n_lock;
            end
        end
        r_neg      <= n_neg;
        r_out_data <= n_out_data;
    end

    `DSAL_ASSERT_IMP(a_ready_idle, s_axis_tready, r_state == S_IDLE)
    `DSAL_ASSERT_IMP(a_done_in_div, w_div_done, r_state == S_DIV)
    `DSAL_ASSERT_IMP(a_start_locked, w_div_start, n_lock != AX_NONE)
    `DSAL_ASSERT_NXT(a_done_to_fin, w_div_done && r_state == S_DIV, r_state == S_FIN)

endmodule
